/* rtl/tspt_pkg.sv */
// Package for the thread slot probe table: field widths, default table size,
// request kinds and the sequencer state type.
// No dependencies; imported by the top level and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package tspt_pkg;

   // Default number of slots in the owner table.
   localparam int SLOTS_DEFAULT = 64;

   // Owner id width and the chunks it is folded in while hashing.
   localparam int ID_W    = 64;
   localparam int CHUNK_W = 16;
   localparam int CHUNKS  = ID_W / CHUNK_W;
   localparam int CHK_W   = $clog2(CHUNKS);

   // Result slot field and its byte-padded stream word.
   localparam int SLOT_W     = 6;
   localparam int RSP_DATA_W = 8;

   // Request kinds carried on the request tuser bit.
   typedef enum logic {
      REQ_CLAIM = 1'b0,
      REQ_FIND  = 1'b1
   } req_kind_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_MUL,
      ST_HASH_BACK,
      ST_HASH_SUB,
      ST_PROBE,
      ST_RESP
   } state_type;

endpackage : tspt_pkg

`default_nettype wire

/* rtl/thread_slot_probe_table.sv */
// Thread slot probe table: open-addressed owner id table with linear probing.
// Contains the hash remainder unit, the probe sequencer and the owner memory.
// Depends on tspt_pkg.
//
// Usage:
//   The request channel (req_) carries one word per request: tdata is the
//   64-bit owner id, tuser selects claim (0) or find (1). A claim takes the
//   first empty slot from the home slot (id mod SLOTS) onward and records the
//   id there; a find returns the first slot holding the id. The result
//   channel (rsp_) returns one word per request: tuser is ok, tdata bits 5:0
//   are the slot index (zero when ok is low).
//   Hashing reduces the id to its home slot 16 bits at a time, each chunk in
//   turn: a shared multiplier forms a reciprocal quotient estimate,
//   multiplies it back by SLOTS, and one compare-and-subtract fixes the
//   remainder. Each probe is then one read of the owner memory, with
//   registered read data. A request probes at most SLOTS slots.
//   One request is in flight at a time; req_tready returns in the cycle after
//   the result word is taken.
//   Reset: synchronous, active high. After reset the block sweeps the owner
//   memory to zero, one slot per cycle, with req_tready low. If the receiver
//   stalls, the result word holds until taken.
`timescale 1ns / 1ps
`default_nettype none

module thread_slot_probe_table
   import tspt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ID_W-1:0]       req_tdata,   // [63:0] thread_id
   input  wire logic                  req_tuser,   // [0] req_type
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [5:0] slot, [7:6] zero
   output logic                       rsp_tuser    // [0] ok
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int V_W   = IDX_W + CHUNK_W;
   // Reciprocal of SLOTS scaled by 2^V_W, rounded down.
   localparam logic [V_W-1:0] RECIP = V_W'((64'd1 << V_W) / 64'(SLOTS));

   // Owner memory: one write port, one registered read port.
   logic [ID_W-1:0] mem_ff [SLOTS];

   state_type        state_ff, state_in;
   req_kind_type     kind_ff, kind_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [ID_W-1:0]  sh_ff, sh_in;
   logic [CHK_W-1:0] chk_ff, chk_in;
   logic [2*V_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff, rd_last_in;
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic [ID_W-1:0]  rd_data_ff;
   logic             rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ID_W-1:0]  wr_data;

   logic [V_W-1:0]   hv;
   logic [V_W-1:0]   mul_a;
   logic [V_W-1:0]   mul_b;
   logic [2*V_W-1:0] mul_p;
   logic [IDX_W:0]   rem_step;
   logic             rem_ge;
   logic [IDX_W-1:0] rem_next;
   logic [IDX_W-1:0] addr_inc;
   logic             clr_last;
   logic             hit;
   logic             fail;
   logic             issue;

   // Shared multiplier: quotient estimate first, then the estimate times SLOTS.
   assign hv    = {rem_ff, sh_ff[ID_W-1 -: CHUNK_W]};
   assign mul_a = (state_ff == ST_HASH_BACK) ? prod_ff[2*V_W-1:V_W] : hv;
   assign mul_b = (state_ff == ST_HASH_BACK) ? V_W'(SLOTS) : RECIP;
   assign mul_p = (2*V_W)'(mul_a) * (2*V_W)'(mul_b);

   // The estimate is low by at most one, so one compare-and-subtract is enough.
   assign rem_step = (IDX_W+1)'(hv - prod_ff[V_W-1:0]);
   assign rem_ge   = (rem_step >= (IDX_W+1)'(SLOTS));
   assign rem_next = rem_ge ? IDX_W'(rem_step - (IDX_W+1)'(SLOTS)) : IDX_W'(rem_step);

   // Probe address steps around the ring.
   assign addr_inc = (addr_ff == IDX_W'(SLOTS - 1)) ? '0 : addr_ff + 1'b1;
   assign clr_last = (clr_ff == IDX_W'(SLOTS - 1));

   // Compare the returned owner word against the request.
   always_comb begin
      hit = 1'b0;
      if (rd_valid_ff) begin
         unique case (kind_ff)
            REQ_CLAIM: hit = (rd_data_ff == '0);
            REQ_FIND:  hit = (rd_data_ff == id_ff);
            default:   hit = 1'b0;
         endcase
      end
   end

   assign fail  = rd_valid_ff && !hit && rd_last_ff;
   assign issue = (state_ff == ST_PROBE) && !hit && (cnt_ff < CNT_W'(SLOTS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (clr_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_tvalid) state_in = ST_HASH_MUL;
         ST_HASH_MUL:  state_in = ST_HASH_BACK;
         ST_HASH_BACK: state_in = ST_HASH_SUB;
         ST_HASH_SUB:  state_in = (chk_ff == CHK_W'(CHUNKS - 1)) ? ST_PROBE : ST_HASH_MUL;
         ST_PROBE:     if (hit || fail) state_in = ST_RESP;
         ST_RESP:      if (rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_CLEAR;
      endcase
   end

   // Datapath and memory write controls.
   always_comb begin
      kind_in     = kind_ff;
      id_in       = id_ff;
      sh_in       = sh_ff;
      chk_in      = chk_ff;
      prod_in     = prod_ff;
      rem_in      = rem_ff;
      clr_in      = clr_ff;
      addr_in     = addr_ff;
      cnt_in      = cnt_ff;
      rd_valid_in = 1'b0;
      rd_last_in  = 1'b0;
      rd_addr_in  = rd_addr_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_slot_in = rsp_slot_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_ff;
      wr_data     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            kind_in = req_kind_type'(req_tuser);
            id_in   = req_tdata;
            sh_in   = req_tdata;
            chk_in  = '0;
            rem_in  = '0;
         end
         ST_HASH_MUL, ST_HASH_BACK: begin
            prod_in = mul_p;
         end
         ST_HASH_SUB: begin
            rem_in = rem_next;
            sh_in  = {sh_ff[ID_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            chk_in = chk_ff + 1'b1;
            if (chk_ff == CHK_W'(CHUNKS - 1)) begin
               addr_in = rem_next;
               cnt_in  = '0;
            end
         end
         ST_PROBE: begin
            if (issue) begin
               rd_valid_in = 1'b1;
               rd_last_in  = (cnt_ff == CNT_W'(SLOTS - 1));
               rd_addr_in  = addr_ff;
               addr_in     = addr_inc;
               cnt_in      = cnt_ff + 1'b1;
            end
            if (hit) begin
               rsp_ok_in   = 1'b1;
               rsp_slot_in = SLOT_W'(rd_addr_ff);
               if (kind_ff == REQ_CLAIM) begin
                  wr_en   = 1'b1;
                  wr_addr = rd_addr_ff;
                  wr_data = id_ff;
               end
            end else if (fail) begin
               rsp_ok_in   = 1'b0;
               rsp_slot_in = '0;
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         rd_valid_ff <= rd_valid_in;
         rd_last_ff  <= rd_last_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      sh_ff       <= sh_in;
      chk_ff      <= chk_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   // Owner memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr_ff];
   end

   // Ports.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = RSP_DATA_W'(rsp_slot_ff);
   assign rsp_tuser  = rsp_ok_ff;

endmodule : thread_slot_probe_table

`default_nettype wire

/* rtl/tspt_checker.sv */
// Port checker for the thread slot probe table, bound to the top level.
// Depends on tspt_pkg and thread_slot_probe_table.
`timescale 1ns / 1ps
`default_nettype none

module tspt_checker
   import tspt_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // The block never takes a request while a result is pending.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request ready while a result is pending");

   // An accepted request closes the request side.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request side still ready after an accept");

   // A failed request reports slot zero.
   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("nonzero slot on a failed request");

   // The memory clearing sweep follows reset, with both sides closed.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");

endmodule : tspt_checker

bind thread_slot_probe_table tspt_checker u_tspt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
